### sv/rrip_pkg.sv
`default_nettype none
package rrip_pkg;

  // prediction values
  localparam logic [1:0] RRPV_MAX  = 2'd3;  // distant re-reference
  localparam logic [1:0] RRPV_NEAR = 2'd2;  // normal fill
  localparam logic [1:0] RRPV_HIT  = 2'd0;  // just re-referenced

  localparam int WAY_OUT_W = 3;

  // back-end sequencer
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_READ  = 3'b010,
    ST_EVAL  = 3'b100
  } back_state_t;

  // one result
  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 replaced_valid;
    logic [31:0]          hit_total;
    logic [31:0]          miss_total;
  } res_t;

endpackage
`default_nettype wire

### sv/rrip_ram.sv
`default_nettype none
module rrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### sv/rrip_front.sv
`default_nettype none
module rrip_front #(
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 64,
  parameter int OFF_W       = $clog2(BLOCK_BYTES),
  parameter int SET_B       = (SETS > 1) ? $clog2(SETS) : 0,
  parameter int IDX_W       = (SET_B > 0) ? SET_B : 1,
  parameter int TAG_W       = 32 - OFF_W - SET_B
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,       // low during the clearing pass
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [31:0]      s_tdata,
  output logic                  q_valid,
  input  wire logic             q_pop,
  output logic      [TAG_W-1:0] q_tag,
  output logic      [IDX_W-1:0] q_idx
);

  // two-entry request queue
  logic [TAG_W-1:0] ent_tag [2];
  logic [IDX_W-1:0] ent_idx [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic             push;
  logic [TAG_W-1:0] in_tag;
  logic [IDX_W-1:0] in_idx;

  assign in_tag   = s_tdata[31 -: TAG_W];
  assign in_idx   = (SET_B == 0) ? '0 : s_tdata[OFF_W +: IDX_W];
  assign s_tready = en && (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (cnt != 2'd0);
  assign q_tag    = ent_tag[rd_ptr];
  assign q_idx    = ent_idx[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_tag[wr_ptr] <= in_tag;
      ent_idx[wr_ptr] <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/rrip_back.sv
`default_nettype none
module rrip_back #(
  parameter int WAYS  = 8,
  parameter int SETS  = 64,
  parameter int IDX_W = 6,
  parameter int TAG_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             insert_distant,
  output logic                  clr_busy,
  input  wire logic             q_valid,
  output logic                  q_pop,
  input  wire logic [TAG_W-1:0] q_tag,
  input  wire logic [IDX_W-1:0] q_idx,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rrip_pkg::res_t        out_res
);
  import rrip_pkg::*;

  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW = TAG_W + 3;      // per way: {rrpv, valid, tag}
  localparam int RW = WAYS * EW;

  back_state_t      state;
  logic [IDX_W-1:0] clr_cnt;
  logic [TAG_W-1:0] cur_tag;
  logic [IDX_W-1:0] cur_idx;
  logic [31:0]      hit_cnt;
  logic [31:0]      miss_cnt;
  logic [31:0]      hit_cnt_next;
  logic [31:0]      miss_cnt_next;

  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [RW-1:0]    rd_data;
  logic [RW-1:0]    wr_data;
  logic             fire;

  logic [TAG_W-1:0] row_tag [WAYS];
  logic             row_val [WAYS];
  logic [1:0]       row_rp  [WAYS];
  logic [TAG_W-1:0] new_tag [WAYS];
  logic             new_val [WAYS];
  logic [1:0]       new_rp  [WAYS];

  logic             hit_any;
  logic             inv_any;
  logic [WW-1:0]    hit_way;
  logic [WW-1:0]    inv_way;
  logic [WW-1:0]    max_way;
  logic [WW-1:0]    vic;
  logic [1:0]       mx;
  logic [1:0]       age;
  logic [1:0]       ins_rp;

  rrip_ram #(
    .WIDTH (RW),
    .DEPTH (SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (q_idx),
    .rd_data (rd_data)
  );

  assign clr_busy = (state == ST_CLEAR);
  assign rd_en    = (state == ST_READ) && q_valid;
  assign q_pop    = rd_en;
  assign fire     = (state == ST_EVAL) && (!out_valid || out_ready);
  assign wr_en    = clr_busy || fire;
  assign wr_addr  = clr_busy ? clr_cnt : cur_idx;
  assign ins_rp   = insert_distant ? RRPV_MAX : RRPV_NEAR;

  // set row decode and way search
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_tag[w] = rd_data[w*EW +: TAG_W];
      row_val[w] = rd_data[w*EW + TAG_W];
      row_rp[w]  = rd_data[w*EW + TAG_W + 1 +: 2];
    end
    hit_any = 1'b0;
    inv_any = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_val[w] && (row_tag[w] == cur_tag)) begin
        hit_any = 1'b1;
        hit_way = WW'(w);
      end
      if (!row_val[w]) begin
        inv_any = 1'b1;
        inv_way = WW'(w);
      end
    end
    // oldest prediction value in the set
    mx = 2'b00;
    for (int w = 0; w < WAYS; w++) begin
      mx[1] = mx[1] | row_rp[w][1];
    end
    for (int w = 0; w < WAYS; w++) begin
      if (row_rp[w][1] == mx[1]) begin
        mx[0] = mx[0] | row_rp[w][0];
      end
    end
    max_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_rp[w] == mx) begin
        max_way = WW'(w);
      end
    end
    // aging until a way reaches 3 is one add of (3 - max)
    age = RRPV_MAX - mx;
    vic = inv_any ? inv_way : max_way;
  end

  // updated row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      new_tag[w] = row_tag[w];
      new_val[w] = row_val[w];
      new_rp[w]  = (!hit_any && !inv_any) ? row_rp[w] + age : row_rp[w];
    end
    if (hit_any) begin
      new_rp[hit_way] = RRPV_HIT;
    end else begin
      new_tag[vic] = cur_tag;
      new_val[vic] = 1'b1;
      new_rp[vic]  = ins_rp;
    end
    // clearing pass writes invalid rows; rrpv of an invalid way is never used
    wr_data = '0;
    if (!clr_busy) begin
      for (int w = 0; w < WAYS; w++) begin
        wr_data[w*EW +: EW] = {new_rp[w], new_val[w], new_tag[w]};
      end
    end
  end

  assign hit_cnt_next  = (hit_cnt == '1) ? hit_cnt : hit_cnt + 32'd1;
  assign miss_cnt_next = (miss_cnt == '1) ? miss_cnt : miss_cnt + 32'd1;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_tag <= q_tag;
      cur_idx <= q_idx;
    end
    if (fire) begin
      out_res.hit            <= hit_any;
      out_res.way            <= WAY_OUT_W'(hit_any ? hit_way : vic);
      out_res.replaced_valid <= !hit_any && !inv_any;
      out_res.hit_total      <= hit_any ? hit_cnt_next : hit_cnt;
      out_res.miss_total     <= hit_any ? miss_cnt : miss_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        if (hit_any) begin
          hit_cnt <= hit_cnt_next;
        end else begin
          miss_cnt <= miss_cnt_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == IDX_W'(SETS - 1)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (q_valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (fire) begin
            state <= ST_READ;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // a set is never read while a row is written back
  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst) !(rd_en && wr_en))
    else $error("set read overlaps write-back");
  // every read is followed by its evaluation
  a_rd_eval: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == ST_EVAL))
    else $error("read not followed by evaluation");
  // a completed request always shows up at the output
  a_fire_out: assert property (@(posedge clk) disable iff (rst) fire |=> out_valid)
    else $error("result lost");
  // a stalled result is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !fire)
    else $error("result overwritten");

endmodule
`default_nettype wire

### sv/rrip_set_assoc_cache_tags.sv
`default_nettype none
// Channel | Dir | Signals                      | Contents
// s_      | in  | s_tvalid s_tready s_tdata    | access address
// m_      | out | m_tvalid m_tready m_tdata    | way, replaced flag, totals
//         |     | m_tuser                      | hit flag
// cfg_    | in  | cfg_wen cfg_wdata            | insert_distant register
//
// In the back end each request first reads its set row from the tag RAM
// (single read port, registered), then does compare, victim pick and
// write-back.  Same-set requests need no forwarding: a row is written before
// the next read issues.  A two-entry queue decouples the input side from it.
// After reset a clearing pass writes all SETS rows, s_tready low.
// A result held in the output register stalls the back end at its next
// evaluation; the queue keeps accepting until it is full.
// BLOCK_BYTES and SETS are powers of two.
module rrip_set_assoc_cache_tags #(
  parameter int WAYS        = 8,
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata,  // insert_distant
  // requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,    // [31:0] address
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,    // [2:0] way, [3] replaced_valid,
                                       // [35:4] hit_total, [67:36] miss_total
  output logic             m_tuser     // [0] hit
);
  import rrip_pkg::*;

  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int SET_B = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int IDX_W = (SET_B > 0) ? SET_B : 1;
  localparam int TAG_W = 32 - OFF_W - SET_B;

  logic             insert_distant;
  logic             clr_busy;
  logic             q_valid;
  logic             q_pop;
  logic [TAG_W-1:0] q_tag;
  logic [IDX_W-1:0] q_idx;
  res_t             res;

  // fill-position register; the user must write it only while idle (the block has no check for this)
  always_ff @(posedge clk) begin
    if (rst) begin
      insert_distant <= 1'b0;
    end else if (cfg_wen) begin
      insert_distant <= cfg_wdata;
    end
  end

  rrip_front #(
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .OFF_W       (OFF_W),
    .SET_B       (SET_B),
    .IDX_W       (IDX_W),
    .TAG_W       (TAG_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (!clr_busy),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_tag    (q_tag),
    .q_idx    (q_idx)
  );

  rrip_back #(
    .WAYS  (WAYS),
    .SETS  (SETS),
    .IDX_W (IDX_W),
    .TAG_W (TAG_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .insert_distant (insert_distant),
    .clr_busy       (clr_busy),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_tag          (q_tag),
    .q_idx          (q_idx),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_res        (res)
  );

  assign m_tdata = {4'b0000, res.miss_total, res.hit_total, res.replaced_valid, res.way};
  assign m_tuser = res.hit;

endmodule
`default_nettype wire
